### sv/lbc_pkg.sv
package lbc_pkg;

    // Default width of the raw time fields that take part in scaling.
    localparam int LBC_TIME_WIDTH = 16;

    // Width of the time, count and command fields on the stream.
    localparam int FIELD_W = 16;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ON    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OFF   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BLINK = 2'd3;

    // Reciprocal of ten for a 16-bit dividend: (x * 52429) >> 19 == x / 10.
    localparam logic [FIELD_W-1:0] RECIP_TEN   = 16'd52429;
    localparam int                 RECIP_SHIFT = 19;

    // Remaining blinks: count plus one, so one bit more than the count field.
    localparam int BLINKS_W = FIELD_W + 1;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] on_time;
        logic [FIELD_W-1:0] off_time;
        logic [FIELD_W-1:0] blink_count;
    } t_item;

    typedef struct packed {
        logic blinking;
        logic led_level;
    } t_result;

endpackage

### sv/lbc_scale.sv
module lbc_scale
    import lbc_pkg::*;
#(
    parameter int TIME_WIDTH = LBC_TIME_WIDTH,
    parameter int TW_EFF     = (TIME_WIDTH < FIELD_W) ? TIME_WIDTH : FIELD_W,
    parameter int RLD_W      = $clog2(((2 ** TW_EFF) - 1) / 10 + 2)
) (
    input  logic [FIELD_W-1:0] i_raw,
    output logic [RLD_W-1:0]   o_ticks
);

    localparam int QUO_W = 2 * FIELD_W - RECIP_SHIFT;

    logic [FIELD_W-1:0]   raw_masked;
    logic [2*FIELD_W-1:0] product;
    logic [QUO_W-1:0]     quotient;
    logic [QUO_W:0]       ticks_full;

    // Only the low TIME_WIDTH bits of a raw time count.
    assign raw_masked = i_raw & FIELD_W'((64'd1 << TW_EFF) - 64'd1);
    assign product    = raw_masked * RECIP_TEN;
    assign quotient   = product[2*FIELD_W-1:RECIP_SHIFT];
    assign ticks_full = {1'b0, quotient} + (QUO_W + 1)'(1);
    assign o_ticks    = ticks_full[RLD_W-1:0];

endmodule

### sv/lbc_core.sv
module lbc_core
    import lbc_pkg::*;
#(
    parameter int TIME_WIDTH = LBC_TIME_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int TW_EFF = (TIME_WIDTH < FIELD_W) ? TIME_WIDTH : FIELD_W;
    localparam int RLD_W  = $clog2(((2 ** TW_EFF) - 1) / 10 + 2);

    logic [RLD_W-1:0]    r_light_reload, n_light_reload;
    logic [RLD_W-1:0]    r_dark_reload,  n_dark_reload;
    logic [RLD_W-1:0]    r_countdown,    n_countdown;
    logic [BLINKS_W-1:0] r_blinks_left,  n_blinks_left;
    logic                r_lit_phase,    n_lit_phase;
    logic                r_led_drive,    n_led_drive;

    logic [FIELD_W-1:0] dark_raw;
    logic [RLD_W-1:0]   light_ticks;
    logic [RLD_W-1:0]   dark_ticks;
    logic [RLD_W-1:0]   cd_dec;

    // A dark time of zero takes the light time.
    assign dark_raw = (i_item.off_time == '0) ? i_item.on_time : i_item.off_time;

    lbc_scale #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_scale_light (
        .i_raw   (i_item.on_time),
        .o_ticks (light_ticks)
    );

    lbc_scale #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_scale_dark (
        .i_raw   (dark_raw),
        .o_ticks (dark_ticks)
    );

    // The countdown stops at one; the phase change happens there.
    assign cd_dec = (r_countdown > RLD_W'(1)) ? (r_countdown - RLD_W'(1)) : r_countdown;

    always_comb begin
        n_light_reload = r_light_reload;
        n_dark_reload  = r_dark_reload;
        n_countdown    = r_countdown;
        n_blinks_left  = r_blinks_left;
        n_lit_phase    = r_lit_phase;
        n_led_drive    = r_led_drive;
        unique case (i_item.cmd)
            CMD_TICK: begin
                if (r_countdown != '0) begin
                    n_countdown = cd_dec;
                    if (cd_dec <= RLD_W'(1) && r_light_reload != '0) begin
                        if (r_blinks_left == BLINKS_W'(1)) begin
                            n_led_drive   = 1'b0;
                            n_countdown   = '0;
                            n_blinks_left = '0;
                            n_lit_phase   = 1'b0;
                        end else if (r_lit_phase) begin
                            n_led_drive = 1'b0;
                            n_countdown = r_dark_reload;
                            n_lit_phase = 1'b0;
                        end else begin
                            // A light phase starting uses up one blink, unless the remaining count is zero.
                            n_led_drive = 1'b1;
                            n_countdown = r_light_reload;
                            n_lit_phase = 1'b1;
                            if (r_blinks_left > BLINKS_W'(1)) begin
                                n_blinks_left = r_blinks_left - BLINKS_W'(1);
                            end
                        end
                    end
                end
            end
            CMD_ON, CMD_OFF: begin
                n_led_drive    = (i_item.cmd == CMD_ON);
                n_light_reload = '0;
                n_dark_reload  = '0;
                n_countdown    = '0;
            end
            CMD_BLINK: begin
                // The phase bit is deliberately left as it stands.
                n_led_drive    = 1'b1;
                n_light_reload = light_ticks;
                n_dark_reload  = dark_ticks;
                n_countdown    = light_ticks;
                n_blinks_left  = (i_item.blink_count == '0) ? '0
                               : ({1'b0, i_item.blink_count} + BLINKS_W'(1));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_reload <= '0;
            r_dark_reload  <= '0;
            r_countdown    <= '0;
            r_blinks_left  <= '0;
            r_lit_phase    <= 1'b0;
            r_led_drive    <= 1'b0;
        end else if (i_advance) begin
            r_light_reload <= n_light_reload;
            r_dark_reload  <= n_dark_reload;
            r_countdown    <= n_countdown;
            r_blinks_left  <= n_blinks_left;
            r_lit_phase    <= n_lit_phase;
            r_led_drive    <= n_led_drive;
        end
    end

    assign o_result.led_level = n_led_drive;
    assign o_result.blinking  = (n_countdown != '0);

    a_blinks_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blinks_left <= BLINKS_W'(65536))
        else $error("remaining blink count out of range");

    a_running_has_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_countdown != '0) |-> (r_light_reload != '0))
        else $error("countdown running without a light reload");

    a_blink_starts_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.cmd == CMD_BLINK) |=> (r_led_drive && r_countdown != '0))
        else $error("blink request did not light the LED");

    a_steady_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && (i_item.cmd == CMD_ON || i_item.cmd == CMD_OFF))
        |=> (r_countdown == '0 && r_light_reload == '0 && r_dark_reload == '0))
        else $error("steady request left the timer running");

endmodule

### sv/led_blink_controller.sv
// Channel  Direction  Handshake              Payload
// s        in         i_s_tvalid/o_s_tready  tuser: cmd; tdata: on_time, off_time, blink_count
// m        out        o_m_tvalid/i_m_tready  tdata: led_level, blinking
//
// One request is taken per cycle while the output is not stalled: an input
// register, a single update of the blink timer state and a result register.
// Loading the input register is the acceptance; the request then passes
// through the timer update into the result register, which offers it.
// Synchronous active-low reset clears the timer state and the valid flags of
// both registers; the LED starts dark and idle.
// A stalled output holds its result while the input register keeps one more
// request; input ready drops only when both are full.
module led_blink_controller
    import lbc_pkg::*;
#(
    parameter int TIME_WIDTH = LBC_TIME_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [15:0] on_time, [31:16] off_time, [47:32] blink_count
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] led_level, [1] blinking, [7:2] zero
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;
    t_result core_result;
    logic    advance;
    logic    in_take;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.cmd         <= i_s_tuser;
            r_in_item.on_time     <= i_s_tdata[15:0];
            r_in_item.off_time    <= i_s_tdata[31:16];
            r_in_item.blink_count <= i_s_tdata[47:32];
        end
    end

    lbc_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= core_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_result.blinking, r_out_result.led_level};

endmodule
